/* rtl/shcbr_pkg.sv */
package shcbr_pkg;

  localparam int COEF_W         = 16;
  localparam int ENTRY_W        = 16;
  localparam int INDEX_W        = 7;
  localparam int POS_W          = 4;
  localparam int DEG_W          = 2;
  localparam int FIELD_CH       = 3;
  localparam int FRAC_SHIFT     = 14;
  localparam int ACC_FN_W       = 40;
  localparam int DEF_CHANNELS   = 3;
  localparam int DEF_MAX_DEGREE = 3;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_COEF = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PASS,
    OP_STORE,
    OP_ROTATE
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    op_t                        op;
    logic [POS_W-1:0]           pos;
    logic [DEG_W-1:0]           band;
    logic [2:0]                 off;
    logic [INDEX_W-1:0]         entry_addr;
    logic signed [ENTRY_W-1:0]  entry_value;
    coef_t [FIELD_CH-1:0]       coefs;
  } cmd_t;

  // entries of all rotated bands up to the given degree
  function automatic int store_depth(input int max_degree);
    int depth;
    depth = 0;
    for (int l = 1; l <= max_degree; l++) begin
      depth = depth + (2 * l + 1) * (2 * l + 1);
    end
    return depth;
  endfunction

  function automatic logic [DEG_W-1:0] band_of(input logic [POS_W-1:0] pos);
    logic [DEG_W-1:0] l;
    if (pos == 4'd0) begin
      l = 2'd0;
    end else if (pos < 4'd4) begin
      l = 2'd1;
    end else if (pos < 4'd9) begin
      l = 2'd2;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  function automatic logic [POS_W-1:0] band_first(input logic [DEG_W-1:0] l);
    logic [POS_W-1:0] f;
    case (l)
      2'd1:    f = 4'd1;
      2'd2:    f = 4'd4;
      2'd3:    f = 4'd9;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [INDEX_W-1:0] band_base(input logic [DEG_W-1:0] l);
    logic [INDEX_W-1:0] b;
    case (l)
      2'd2:    b = 7'd9;
      2'd3:    b = 7'd34;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

  // add half an lsb, floor by the fraction shift, clamp to 16 bits
  function automatic coef_t round_sat(input logic signed [ACC_FN_W-1:0] a);
    localparam logic signed [ACC_FN_W:0] BIAS    = (ACC_FN_W+1)'(1 << (FRAC_SHIFT - 1));
    localparam logic signed [ACC_FN_W:0] SAT_MAX = (ACC_FN_W+1)'(32767);
    localparam logic signed [ACC_FN_W:0] SAT_MIN = -(ACC_FN_W+1)'(32768);
    logic signed [ACC_FN_W:0] v;
    logic signed [ACC_FN_W:0] q;
    coef_t r;
    v = (ACC_FN_W+1)'(a) + BIAS;
    q = v >>> FRAC_SHIFT;
    if (q > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (q < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = COEF_W'(q);
    end
    return r;
  endfunction

endpackage

/* rtl/shcbr_if.sv */
interface shcbr_cfg_if;
  import shcbr_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] band_degree;
  modport source (output valid, output band_degree, input ready);
  modport sink (input valid, input band_degree, output ready);
endinterface

interface shcbr_in_if;
  import shcbr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [ENTRY_W-1:0] entry_value;
  logic signed [COEF_W-1:0]  coef_red;
  logic signed [COEF_W-1:0]  coef_green;
  logic signed [COEF_W-1:0]  coef_blue;
  modport source (output valid, output mode, output entry_index, output entry_value,
                  output coef_red, output coef_green, output coef_blue, input ready);
  modport sink (input valid, input mode, input entry_index, input entry_value,
                input coef_red, input coef_green, input coef_blue, output ready);
endinterface

interface shcbr_out_if;
  import shcbr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] out_red;
  logic signed [COEF_W-1:0] out_green;
  logic signed [COEF_W-1:0] out_blue;
  logic                     last_of_run;
  modport source (output valid, output coef_index, output out_red, output out_green,
                  output out_blue, output last_of_run, input ready);
  modport sink (input valid, input coef_index, input out_red, input out_green,
                input out_blue, input last_of_run, output ready);
endinterface

/* rtl/shcbr_front.sv */
module shcbr_front #(
  parameter int CHANNELS   = shcbr_pkg::DEF_CHANNELS,
  parameter int MAX_DEGREE = shcbr_pkg::DEF_MAX_DEGREE
) (
  input  logic             clk,
  input  logic             rst,
  shcbr_cfg_if.sink        cfg,
  shcbr_in_if.sink         feed,
  output logic             push,
  output shcbr_pkg::cmd_t  push_cmd,
  input  logic             full
);
  import shcbr_pkg::*;

  localparam int LANES       = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;
  localparam int STORE_DEPTH = store_depth(MAX_DEGREE);
  localparam logic [DEG_W-1:0]   MAX_DEG_L = DEG_W'(MAX_DEGREE);
  localparam logic [INDEX_W-1:0] DEPTH_L   = INDEX_W'(STORE_DEPTH);

  logic [DEG_W-1:0] band_degree;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic             accept;
  logic [DEG_W-1:0] l;
  logic [DEG_W-1:0] active;
  logic [POS_W-1:0] off;
  coef_t [FIELD_CH-1:0] raw;

  assign cfg.ready  = 1'b1;
  assign feed.ready = !full;
  assign accept     = feed.valid && !full;

  assign raw[0] = feed.coef_red;
  assign raw[1] = feed.coef_green;
  assign raw[2] = feed.coef_blue;

  assign l      = band_of(position);
  assign active = (band_degree > MAX_DEG_L) ? MAX_DEG_L : band_degree;
  assign off    = position - band_first(l);

  always_comb begin
    position_next        = position;
    push                 = 1'b0;
    push_cmd.pos         = position;
    push_cmd.band        = l;
    push_cmd.off         = 3'(off);
    push_cmd.entry_addr  = feed.entry_index;
    push_cmd.entry_value = feed.entry_value;
    push_cmd.op          = OP_PASS;
    for (int ch = 0; ch < FIELD_CH; ch++) begin
      push_cmd.coefs[ch] = (ch < LANES) ? raw[ch] : '0;
    end
    if (feed.mode == MODE_LOAD) begin
      push_cmd.op = OP_LOAD;
      push        = accept && (feed.entry_index < DEPTH_L);
    end else begin
      position_next = accept ? position + 1'b1 : position;
      push          = accept;
      if (l == 2'd0 || l > active) begin
        push_cmd.op = OP_PASS;
      end else if (off == POS_W'({l, 1'b0})) begin
        push_cmd.op = OP_ROTATE;
      end else begin
        push_cmd.op = OP_STORE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_degree <= '0;
      position    <= '0;
    end else begin
      if (cfg.valid) begin
        band_degree <= cfg.band_degree;
      end
      position <= position_next;
    end
  end

endmodule

/* rtl/shcbr_queue.sv */
module shcbr_queue #(
  parameter int DEPTH = shcbr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  shcbr_pkg::cmd_t  push_cmd,
  output logic             full,
  output logic             pop_valid,
  output shcbr_pkg::cmd_t  pop_cmd,
  input  logic             pop
);
  import shcbr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cmd_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/shcbr_back.sv */
module shcbr_back #(
  parameter int CHANNELS   = shcbr_pkg::DEF_CHANNELS,
  parameter int MAX_DEGREE = shcbr_pkg::DEF_MAX_DEGREE
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  shcbr_pkg::cmd_t  pop_cmd,
  output logic             pop,
  shcbr_out_if.source      result
);
  import shcbr_pkg::*;

  localparam int LANES       = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;
  localparam int STORE_DEPTH = store_depth(MAX_DEGREE);
  localparam int BUF_DEPTH   = 2 * MAX_DEGREE + 1;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int BW          = $clog2(BUF_DEPTH);
  localparam int PROD_W      = COEF_W + ENTRY_W;
  localparam int ACC_W       = PROD_W + BW;

  back_state_t state;
  back_state_t state_next;

  logic signed [ENTRY_W-1:0] mstore [STORE_DEPTH];
  coef_t [LANES-1:0]         bstore [BUF_DEPTH];

  logic [AW-1:0]             maddr;
  logic [BW-1:0]             col;
  logic [BW-1:0]             row;
  logic [BW-1:0]             kl;
  logic [DEG_W-1:0]          band;
  logic signed [ENTRY_W-1:0] mdata;
  coef_t [LANES-1:0]         bdata;
  logic signed [PROD_W-1:0]  prod [LANES];
  logic signed [ACC_W-1:0]   acc [LANES];
  coef_t [FIELD_CH-1:0]      rnd;

  logic p1_valid;
  logic p1_last;
  logic p2_valid;
  logic p2_last;
  logic row_done;

  logic                 out_valid;
  logic [POS_W-1:0]     out_index;
  coef_t [FIELD_CH-1:0] out_coef;
  logic                 out_last;
  logic                 out_free;

  logic mem_we;
  logic buf_we;
  logic pass_load;
  logic rot_start;
  logic issue;
  logic emit_load;

  assign out_free = !out_valid || result.ready;

  assign result.valid       = out_valid;
  assign result.coef_index  = out_index;
  assign result.out_red     = out_coef[0];
  assign result.out_green   = out_coef[1];
  assign result.out_blue    = out_coef[2];
  assign result.last_of_run = out_last;

  for (genvar ch = 0; ch < FIELD_CH; ch++) begin : g_rnd
    if (ch < LANES) begin : g_on
      assign rnd[ch] = round_sat(ACC_FN_W'(acc[ch]));
    end else begin : g_off
      assign rnd[ch] = '0;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    buf_we     = 1'b0;
    pass_load  = 1'b0;
    rot_start  = 1'b0;
    issue      = 1'b0;
    emit_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.op)
            OP_LOAD: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            OP_STORE: begin
              buf_we = 1'b1;
              pop    = 1'b1;
            end
            OP_PASS: begin
              if (out_free) begin
                pass_load = 1'b1;
                pop       = 1'b1;
              end
            end
            OP_ROTATE: begin
              buf_we     = 1'b1;
              pop        = 1'b1;
              rot_start  = 1'b1;
              state_next = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (col == kl) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (row_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_load  = 1'b1;
          state_next = (row == kl) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p1_valid  <= 1'b0;
      p1_last   <= 1'b0;
      p2_valid  <= 1'b0;
      p2_last   <= 1'b0;
      row_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      p1_last  <= issue && (col == kl);
      p2_valid <= p1_valid;
      p2_last  <= p1_valid && p1_last;
      row_done <= p2_valid && p2_last;
      if (pass_load || emit_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // matrix store and band buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mstore[pop_cmd.entry_addr[AW-1:0]] <= pop_cmd.entry_value;
    end
    mdata <= mstore[maddr];
    if (buf_we) begin
      bstore[pop_cmd.off[BW-1:0]] <= pop_cmd.coefs[LANES-1:0];
    end
    bdata <= bstore[col];
  end

  // sequencing and one multiply-accumulate lane per channel
  always_ff @(posedge clk) begin
    if (rot_start) begin
      band  <= pop_cmd.band;
      kl    <= BW'({pop_cmd.band, 1'b0});
      maddr <= AW'(band_base(pop_cmd.band));
      col   <= '0;
      row   <= '0;
    end else if (issue) begin
      maddr <= maddr + 1'b1;
      col   <= (col == kl) ? '0 : col + 1'b1;
    end else if (emit_load) begin
      row <= row + 1'b1;
    end
    for (int ch = 0; ch < LANES; ch++) begin
      if (p1_valid) begin
        prod[ch] <= mdata * bdata[ch];
      end
      if (rot_start || emit_load) begin
        acc[ch] <= '0;
      end else if (p2_valid) begin
        acc[ch] <= acc[ch] + ACC_W'(prod[ch]);
      end
    end
    if (pass_load) begin
      out_index <= pop_cmd.pos;
      out_coef  <= pop_cmd.coefs;
      out_last  <= 1'b1;
    end else if (emit_load) begin
      out_index <= band_first(band) + POS_W'(row);
      out_coef  <= rnd;
      out_last  <= (row == kl);
    end
  end

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("pop from empty queue");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (col <= kl))
    else $error("column beyond band width");
  a_done_drain: assert property (@(posedge clk) disable iff (rst)
    row_done |-> (state == ST_DRAIN))
    else $error("row completed outside drain");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (pass_load || emit_load) |-> (!out_valid || result.ready))
    else $error("output register overwritten");
`endif

endmodule

/* rtl/sh_coefficient_band_rotate.sv */
// Rotates real spherical-harmonic coefficients of degree up to MAX_DEGREE for up to three
// colour channels. Coefficient items arrive in index order 0 to 15; load items write one
// matrix entry (flat index: band 1 at 0, band 2 at 9, band 3 at 34, row-major) and make no
// result. Coefficient 0 and bands above band_degree or MAX_DEGREE come out in the cycle
// after leaving the queue; other coefficients are buffered, and the last one of a band of
// k = 2l+1 produces k results. A front stage classifies items into a QUEUE_DEPTH command
// queue, so input is taken at one item per cycle until the queue fills. The back end takes
// load, store and pass items while idle (a pass item once the output register is free) and
// no new item during a rotation, which per row issues k reads on the single read port
// of the matrix store, accumulates them through read, product and accumulator registers,
// then rounds and hands over each row. Results are Q3.12, rounded half up and saturated.
// band_degree must be written by the user only while idle; the block does not enforce it.
module sh_coefficient_band_rotate #(
  parameter int CHANNELS    = shcbr_pkg::DEF_CHANNELS,
  parameter int MAX_DEGREE  = shcbr_pkg::DEF_MAX_DEGREE,
  parameter int QUEUE_DEPTH = shcbr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  shcbr_cfg_if.sink   cfg,
  shcbr_in_if.sink    feed,
  shcbr_out_if.source result
);
  import shcbr_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop;

  shcbr_front #(
    .CHANNELS   (CHANNELS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .feed     (feed),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  shcbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop)
  );

  shcbr_back #(
    .CHANNELS   (CHANNELS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .result    (result)
  );

endmodule
